@@ rtl/jacobi_3d_stencil_sweep_core_defines.svh @@
// Assertion macros used by the stencil sweep back end.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef JACOBI_3D_STENCIL_SWEEP_CORE_DEFINES_SVH
`define JACOBI_3D_STENCIL_SWEEP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jsc_pkg.sv @@
// Shared constants and types for the 3-D Jacobi stencil sweep core.
// No dependencies.
package jsc_pkg;

  localparam int MAX_EDGE_DEF = 64;
  localparam int EDGE_RESET   = 64;

  localparam int EDGE_W = 7;
  localparam int VAL_W  = 32;
  localparam int RES_W  = 31;
  localparam int POS_W  = 6;
  localparam int PSUM_W = 34;
  localparam int SUM_W  = 35;

  localparam logic [RES_W-1:0] THRESH_RESET = 31'd1;
  localparam logic [RES_W-1:0] RES_SAT      = 31'h7FFF_FFFF;

  // Configuration port
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 31;
  localparam logic [CFG_IW-1:0] CFG_GRID_EDGE   = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_CONV_THRESH = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // Divide by three through reciprocals: (2^17+1)/3 and (2^19+1)/3
  localparam logic [16:0] RECIP3_HI = 17'd43691;
  localparam logic [17:0] RECIP3_LO = 18'd174763;

  typedef struct packed {
    logic [POS_W-1:0] plane;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic signed [PSUM_W-1:0] sum_a;
    logic signed [PSUM_W-1:0] sum_b;
    logic signed [VAL_W-1:0]  center;
    tag_t                     tag;
  } item_t;

  typedef struct packed {
    logic              restart;
    logic [EDGE_W-1:0] grid_edge;
  } cfg_t;

endpackage

@@ rtl/jsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/jsc_delay.sv @@
// Programmable delay line: output is the input from len advances ago.
// Depends on jsc_ram.
module jsc_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic                         adv,
  input  logic [$clog2(DEPTH+1)-1:0]   len,
  input  logic [WIDTH-1:0]             din,
  output logic [WIDTH-1:0]             dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic             byp_r, byp_nxt;
  logic [WIDTH-1:0] byp_data_r;
  logic [WIDTH-1:0] ram_q;
  logic             wr;

  assign wr = adv && !restart;

  always_comb begin
    if (restart) begin
      ptr_nxt = '0;
    end else if (adv) begin
      if (ptr_r == AW'(len - LW'(1))) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + AW'(1);
      end
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  // Read the slot for the next advance; forward the write when it is the same slot.
  assign byp_nxt = wr && (ptr_nxt == ptr_r);

  jsc_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr),
    .waddr(ptr_r),
    .wdata(din),
    .raddr(ptr_nxt),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      byp_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      byp_r <= byp_nxt;
    end
    byp_data_r <= din;
  end

  assign dout = byp_r ? byp_data_r : ram_q;

endmodule

@@ rtl/jsc_front.sv @@
// Front end: raster counters, plane/row delay lines and interior classification.
// Depends on jsc_pkg and jsc_delay.
module jsc_front #(
  parameter int MAX_EDGE = jsc_pkg::MAX_EDGE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  jsc_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [jsc_pkg::VAL_W-1:0]  in_cell_value,
  output logic                              push,
  output jsc_pkg::item_t                    push_item,
  input  logic                              q_full
);

  localparam int CW  = $clog2(MAX_EDGE);
  localparam int EW  = $clog2(MAX_EDGE + 1);
  localparam int PD  = MAX_EDGE * MAX_EDGE - MAX_EDGE;
  localparam int RD  = MAX_EDGE - 1;
  localparam int PLW = $clog2(PD + 1);
  localparam int EDGE_RST = (jsc_pkg::EDGE_RESET > MAX_EDGE) ? MAX_EDGE : jsc_pkg::EDGE_RESET;
  localparam int LENP_RST = EDGE_RST * EDGE_RST - EDGE_RST;
  localparam int LENR_RST = EDGE_RST - 1;

  logic [EW-1:0]     edge_c;
  logic [2*EW-1:0]   edge_sq;
  logic [PLW-1:0]    lenp_r;
  logic [CW-1:0]     lenr_r;
  logic [CW-1:0]     em2;
  logic [CW-1:0]     p_r, r_r, c_r, p_nxt, r_nxt, c_nxt;
  logic              accept, interior, last;

  logic signed [jsc_pkg::VAL_W-1:0] tap_pe, tap_pp, tap_me, tap_2;
  logic signed [jsc_pkg::VAL_W-1:0] ctr_r, tap_pm_r;

  // Clamp the edge into its legal range and derive the delay lengths.
  always_comb begin
    if (cfg.grid_edge < 7'd3) begin
      edge_c = EW'(3);
    end else if (int'(cfg.grid_edge) > MAX_EDGE) begin
      edge_c = EW'(MAX_EDGE);
    end else begin
      edge_c = EW'(cfg.grid_edge);
    end
  end

  assign edge_sq = edge_c * edge_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lenp_r <= PLW'(LENP_RST);
      lenr_r <= CW'(LENR_RST);
    end else if (cfg.restart) begin
      lenp_r <= PLW'(edge_sq - (2*EW)'(edge_c));
      lenr_r <= CW'(edge_c - EW'(1));
    end
  end

  assign em2      = lenr_r - CW'(1);
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Raster position of the arriving cell
  always_comb begin
    p_nxt = p_r;
    r_nxt = r_r;
    c_nxt = c_r;
    if (cfg.restart) begin
      p_nxt = '0;
      r_nxt = '0;
      c_nxt = '0;
    end else if (accept) begin
      if (c_r == lenr_r) begin
        c_nxt = '0;
        if (r_r == lenr_r) begin
          r_nxt = '0;
          p_nxt = (p_r == lenr_r) ? '0 : p_r + CW'(1);
        end else begin
          r_nxt = r_r + CW'(1);
        end
      end else begin
        c_nxt = c_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
      r_r <= '0;
      c_r <= '0;
    end else begin
      p_r <= p_nxt;
      r_r <= r_nxt;
      c_r <= c_nxt;
    end
  end

  // Window chain: plane delay, row delay, two cell registers, row delay, plane delay.
  jsc_delay #(.WIDTH(jsc_pkg::VAL_W), .DEPTH(PD)) u_dl_plane_a (
    .clk(clk), .rst_n(rst_n), .restart(cfg.restart), .adv(accept),
    .len(lenp_r), .din(in_cell_value), .dout(tap_pe)
  );

  jsc_delay #(.WIDTH(jsc_pkg::VAL_W), .DEPTH(RD)) u_dl_row_a (
    .clk(clk), .rst_n(rst_n), .restart(cfg.restart), .adv(accept),
    .len(lenr_r), .din(tap_pe), .dout(tap_pp)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      ctr_r    <= tap_pp;
      tap_pm_r <= ctr_r;
    end
  end

  jsc_delay #(.WIDTH(jsc_pkg::VAL_W), .DEPTH(RD)) u_dl_row_b (
    .clk(clk), .rst_n(rst_n), .restart(cfg.restart), .adv(accept),
    .len(lenr_r), .din(tap_pm_r), .dout(tap_me)
  );

  jsc_delay #(.WIDTH(jsc_pkg::VAL_W), .DEPTH(PD)) u_dl_plane_b (
    .clk(clk), .rst_n(rst_n), .restart(cfg.restart), .adv(accept),
    .len(lenp_r), .din(tap_me), .dout(tap_2)
  );

  assign interior = (p_r >= CW'(2)) && (r_r != '0) && (r_r <= em2) &&
                    (c_r != '0) && (c_r <= em2);
  assign last     = (p_r == lenr_r) && (r_r == em2) && (c_r == em2);

  assign push = accept && interior;

  always_comb begin
    push_item.sum_a     = jsc_pkg::PSUM_W'(in_cell_value) + jsc_pkg::PSUM_W'(tap_2) +
                          jsc_pkg::PSUM_W'(tap_pm_r);
    push_item.sum_b     = jsc_pkg::PSUM_W'(tap_pp) + jsc_pkg::PSUM_W'(tap_me) +
                          jsc_pkg::PSUM_W'(tap_pe);
    push_item.center    = ctr_r;
    push_item.tag.plane = jsc_pkg::POS_W'(p_r - CW'(1));
    push_item.tag.row   = jsc_pkg::POS_W'(r_r);
    push_item.tag.col   = jsc_pkg::POS_W'(c_r);
    push_item.tag.last  = last;
  end

endmodule

@@ rtl/jsc_fifo.sv @@
// Short register queue between front and back ends.
// No dependencies.
module jsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  assign full  = (count_r == NW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

@@ rtl/jsc_back.sv @@
// Back end: stencil sum, divide by six, residual tracking and output register.
// Depends on jsc_pkg and the assertion macro header.
`include "jacobi_3d_stencil_sweep_core_defines.svh"

module jsc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              restart,
  input  logic [jsc_pkg::RES_W-1:0]         thresh,
  input  jsc_pkg::item_t                    q_item,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [jsc_pkg::VAL_W-1:0]  out_new_value,
  output logic [jsc_pkg::POS_W-1:0]         out_plane_pos,
  output logic [jsc_pkg::POS_W-1:0]         out_row_pos,
  output logic [jsc_pkg::POS_W-1:0]         out_col_pos,
  output logic [jsc_pkg::RES_W-1:0]         out_residual_max,
  output logic                              out_converged,
  output logic                              out_sweep_last
);

  localparam int VW = jsc_pkg::VAL_W;
  localparam int RW = jsc_pkg::RES_W;

  logic adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  jsc_pkg::tag_t tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r, tag7_r;
  logic signed [VW-1:0] ctr1_r, ctr2_r, ctr3_r, ctr4_r, ctr5_r;

  logic signed [jsc_pkg::SUM_W-1:0] sum1_r, mag2;
  logic        neg2_r, neg3_r, neg4_r;
  logic [32:0] n2_r;
  logic [32:0] prod3, prod3_r;
  logic [15:0] nh3_r;
  logic [16:0] nl3_r;
  logic [15:0] qh, qh4_r;
  logic [1:0]  rh;
  logic [18:0] t4;
  logic [36:0] prod4, prod4_r;
  logic [32:0] q5;
  logic signed [33:0] qs5, nv5;
  logic signed [VW-1:0] nv5_r, nv6_r, nv7_r;
  logic signed [32:0] diff6_r;
  logic [32:0] absd;
  logic [RW-1:0] mag7_r;

  logic [RW-1:0] res;
  logic          conv;
  logic          out_valid_r;
  logic signed [VW-1:0] out_new_value_r;
  logic [jsc_pkg::POS_W-1:0] out_plane_pos_r, out_row_pos_r, out_col_pos_r;
  logic [RW-1:0] out_residual_max_r, run_r;
  logic          out_converged_r, out_sweep_last_r;

  // The whole pipeline moves when the output register can take a beat.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign mag2  = sum1_r[jsc_pkg::SUM_W-1] ? -sum1_r : sum1_r;
  assign prod3 = 33'(n2_r[32:17]) * 33'(jsc_pkg::RECIP3_HI);
  assign qh    = prod3_r[32:17];
  assign rh    = 2'(nh3_r - 16'(qh * 16'd3));
  assign t4    = {rh, nl3_r};
  assign prod4 = 37'(t4) * 37'(jsc_pkg::RECIP3_LO);
  assign q5    = {qh4_r, prod4_r[35:19]};
  assign qs5   = $signed({1'b0, q5});
  assign nv5   = neg4_r ? -qs5 : qs5;
  assign absd  = diff6_r[32] ? 33'(-diff6_r) : 33'(diff6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // sum of six taps
      sum1_r  <= jsc_pkg::SUM_W'(q_item.sum_a) + jsc_pkg::SUM_W'(q_item.sum_b);
      ctr1_r  <= q_item.center;
      tag1_r  <= q_item.tag;
      // magnitude, halved: |s|/6 = (|s|/2)/3
      neg2_r  <= sum1_r[jsc_pkg::SUM_W-1];
      n2_r    <= 33'(mag2[jsc_pkg::SUM_W-2:1]);
      ctr2_r  <= ctr1_r;
      tag2_r  <= tag1_r;
      // upper digit divided by three
      prod3_r <= prod3;
      nh3_r   <= n2_r[32:17];
      nl3_r   <= n2_r[16:0];
      neg3_r  <= neg2_r;
      ctr3_r  <= ctr2_r;
      tag3_r  <= tag2_r;
      // remainder joined with lower digit, divided by three
      qh4_r   <= qh;
      prod4_r <= prod4;
      neg4_r  <= neg3_r;
      ctr4_r  <= ctr3_r;
      tag4_r  <= tag3_r;
      // restore sign
      nv5_r   <= VW'(nv5);
      ctr5_r  <= ctr4_r;
      tag5_r  <= tag4_r;
      // change against old value
      diff6_r <= 33'(ctr5_r) - 33'(nv5_r);
      nv6_r   <= nv5_r;
      tag6_r  <= tag5_r;
      // saturate magnitude
      mag7_r  <= (absd[32:31] != 2'b00) ? jsc_pkg::RES_SAT : absd[RW-1:0];
      nv7_r   <= nv6_r;
      tag7_r  <= tag6_r;
    end
  end

  assign res  = (mag7_r > run_r) ? mag7_r : run_r;
  assign conv = tag7_r.last && (mag7_r < thresh) && (run_r < thresh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= v7_r;
      end
      if (restart) begin
        run_r <= '0;
      end else if (adv && v7_r) begin
        run_r <= tag7_r.last ? '0 : res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v7_r) begin
      out_new_value_r    <= nv7_r;
      out_plane_pos_r    <= tag7_r.plane;
      out_row_pos_r      <= tag7_r.row;
      out_col_pos_r      <= tag7_r.col;
      out_residual_max_r <= res;
      out_converged_r    <= conv;
      out_sweep_last_r   <= tag7_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_value    = out_new_value_r;
  assign out_plane_pos    = out_plane_pos_r;
  assign out_row_pos      = out_row_pos_r;
  assign out_col_pos      = out_col_pos_r;
  assign out_residual_max = out_residual_max_r;
  assign out_converged    = out_converged_r;
  assign out_sweep_last   = out_sweep_last_r;

  `JSC_ASSERT_IMPL(a_conv_on_last, out_valid_r && out_converged_r, out_sweep_last_r,
    "converged flagged on a result that is not the end of the sweep")
  `JSC_ASSERT_NEXT(a_max_not_below_run, adv && v7_r, out_residual_max_r >= $past(run_r),
    "reported residual maximum fell below the running maximum")
  `JSC_ASSERT_NEXT(a_run_clears_at_end, adv && v7_r && tag7_r.last, run_r == '0,
    "running maximum not cleared after the final interior cell")

endmodule

@@ rtl/jacobi_3d_stencil_sweep_core.sv @@
// Top level of the 3-D seven-point Jacobi sweep core.
// Depends on jsc_pkg, jsc_front, jsc_fifo and jsc_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_cell_value): one signed Q16.16 cell
//   per beat, raster order plane, row, column, sweep after sweep with no gap.
//   Result channel (out_valid / out_stall / out_*): one beat per interior cell,
//   carrying the relaxed value, its coordinates, the running residual maximum,
//   and on the final interior cell sweep_last plus the converged flag.
//   Config port (cfg_we / cfg_index / cfg_data): write grid_edge or
//   conv_threshold while idle; a grid_edge write restarts the sweep.
// Timing:
//   Throughput is one cell per clock while in_stall is low. The result
//   for cell (p,r,c) is computed on the beat that delivers (p+1,r,c); it
//   passes the queue, seven arithmetic stages (sum, magnitude, two reciprocal
//   multiplies for the divide by six, sign, difference, saturation), and the
//   output register that holds the running maximum.
//   The window lives in four RAM delay lines (two of E*E-E words, two of E-1).
// Reset: counters, queue and running maximum clear; no memory clearing pass.
// Backpressure: out_stall freezes the back end while a result is held; the
//   four-entry queue absorbs beats, then in_stall rises while the queue is full.
module jacobi_3d_stencil_sweep_core #(
  parameter int MAX_EDGE = jsc_pkg::MAX_EDGE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [jsc_pkg::VAL_W-1:0]   in_cell_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [jsc_pkg::VAL_W-1:0]   out_new_value,
  output logic [jsc_pkg::POS_W-1:0]          out_plane_pos,
  output logic [jsc_pkg::POS_W-1:0]          out_row_pos,
  output logic [jsc_pkg::POS_W-1:0]          out_col_pos,
  output logic [jsc_pkg::RES_W-1:0]          out_residual_max,
  output logic                               out_converged,
  output logic                               out_sweep_last,
  input  logic                               cfg_we,
  input  logic [jsc_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [jsc_pkg::CFG_DW-1:0]         cfg_data
);

  jsc_pkg::cfg_t               cfg;
  logic [jsc_pkg::RES_W-1:0]   thresh_r;
  logic                        push, q_full, q_empty, q_pop;
  jsc_pkg::item_t              push_item, q_item;

  // Decode config writes; the edge goes to the front end raw, clamped there.
  assign cfg.restart   = cfg_we && (cfg_index == jsc_pkg::CFG_GRID_EDGE);
  assign cfg.grid_edge = cfg_data[jsc_pkg::EDGE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= jsc_pkg::THRESH_RESET;
    end else if (cfg_we && (cfg_index == jsc_pkg::CFG_CONV_THRESH)) begin
      thresh_r <= cfg_data[jsc_pkg::RES_W-1:0];
    end
  end

  // Front: count position, run the window, push interior cells.
  jsc_front #(
    .MAX_EDGE(MAX_EDGE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_value(in_cell_value),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // Queue: decouple the window from the arithmetic pipeline.
  jsc_fifo #(
    .WIDTH($bits(jsc_pkg::item_t)),
    .DEPTH(jsc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(push_item),
    .pop  (q_pop),
    .rdata(q_item),
    .full (q_full),
    .empty(q_empty)
  );

  // Back: divide, track residual, hold the result beat.
  jsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .restart         (cfg.restart),
    .thresh          (thresh_r),
    .q_item          (q_item),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_value   (out_new_value),
    .out_plane_pos   (out_plane_pos),
    .out_row_pos     (out_row_pos),
    .out_col_pos     (out_col_pos),
    .out_residual_max(out_residual_max),
    .out_converged   (out_converged),
    .out_sweep_last  (out_sweep_last)
  );

endmodule
